### sv/smds_pkg.sv
// ----------------------------------------------------------------------------
// smds_pkg: shared types and constants
// Beat format passed along the divider chain, and fixed widths.
// ----------------------------------------------------------------------------
package smds_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIV_CELLS = DATA_W;

    localparam logic [DATA_W-1:0] SAT_MAG = 32'h7FFF_FFFF;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              sat;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dvd;
        logic [DATA_W-1:0] dsr;
    } div_beat_t;

endpackage

### sv/smds_front.sv
// ----------------------------------------------------------------------------
// smds_front: operand magnitudes and product
// Three register stages: magnitudes and sign, 64-bit product, overflow test.
// ----------------------------------------------------------------------------
module smds_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [smds_pkg::DATA_W-1:0] a,
    input  logic signed [smds_pkg::DATA_W-1:0] b,
    input  logic signed [smds_pkg::DATA_W-1:0] c,
    output smds_pkg::div_beat_t               beat_out
);
    localparam int unsigned W = smds_pkg::DATA_W;

    logic         v1_reg, v2_reg;
    logic         neg1_reg, neg2_reg;
    logic [W-1:0] ma_reg, mb_reg, mc1_reg, mc2_reg;
    logic [2*W-1:0] prod_reg;
    smds_pkg::div_beat_t beat_reg, beat_next;

    logic [W-1:0] ma_next, mb_next, mc_next;

    assign ma_next = a[W-1] ? (~a + 1'b1) : a;
    assign mb_next = b[W-1] ? (~b + 1'b1) : b;
    assign mc_next = c[W-1] ? (~c + 1'b1) : c;

    always_comb begin
        beat_next.valid = v2_reg;
        beat_next.neg   = neg2_reg;
        beat_next.sat   = (prod_reg[2*W-1:W] >= mc2_reg);
        beat_next.rem   = prod_reg[2*W-1:W];
        beat_next.dvd   = prod_reg[W-1:0];
        beat_next.dsr   = mc2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            beat_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg         <= in_valid;
            v2_reg         <= v1_reg;
            beat_reg.valid <= beat_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg        <= ma_next;
            mb_reg        <= mb_next;
            mc1_reg       <= mc_next;
            neg1_reg      <= a[W-1] ^ b[W-1] ^ c[W-1];
            prod_reg      <= ma_reg * mb_reg;
            mc2_reg       <= mc1_reg;
            neg2_reg      <= neg1_reg;
            beat_reg.neg  <= beat_next.neg;
            beat_reg.sat  <= beat_next.sat;
            beat_reg.rem  <= beat_next.rem;
            beat_reg.dvd  <= beat_next.dvd;
            beat_reg.dsr  <= beat_next.dsr;
        end
    end

    assign beat_out = beat_reg;

endmodule

### sv/smds_div_cell.sv
// ----------------------------------------------------------------------------
// smds_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and develops one quotient bit.
// ----------------------------------------------------------------------------
module smds_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  smds_pkg::div_beat_t beat_in,
    output smds_pkg::div_beat_t beat_out
);
    localparam int unsigned W = smds_pkg::DATA_W;

    smds_pkg::div_beat_t beat_reg, beat_next;
    logic [W:0] trial;
    logic [W:0] diff;
    logic       take;

    assign trial = {beat_in.rem, beat_in.dvd[W-1]};
    assign diff  = trial - {1'b0, beat_in.dsr};
    assign take  = ~diff[W];

    always_comb begin
        beat_next     = beat_in;
        // quotient bits fill the dividend register from the bottom
        beat_next.rem = take ? diff[W-1:0] : trial[W-1:0];
        beat_next.dvd = {beat_in.dvd[W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (en) begin
            beat_reg.valid <= beat_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg.neg <= beat_next.neg;
            beat_reg.sat <= beat_next.sat;
            beat_reg.rem <= beat_next.rem;
            beat_reg.dvd <= beat_next.dvd;
            beat_reg.dsr <= beat_next.dsr;
        end
    end

    assign beat_out = beat_reg;

endmodule

### sv/signed_mul_div_saturate.sv
// ----------------------------------------------------------------------------
// signed_mul_div_saturate: signed a*b/c with saturation
// Fully pipelined: one operand set per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Computes a*b/c on magnitudes, truncated, with the sign the xor of the operand
// signs. If the upper product word is at least |c| (including c of zero) the
// result is +/-0x7FFFFFFF and m_saturated is set. A new beat is taken every
// cycle unless the output stalls; stages: three front ones (magnitude, 32x32
// multiply, overflow test), 32 divider cells each resolving one quotient bit,
// and the output register. The whole pipe holds while a result waits.
module signed_mul_div_saturate (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [smds_pkg::DATA_W-1:0] s_multiplicand,
    input  logic signed [smds_pkg::DATA_W-1:0] s_multiplier,
    input  logic signed [smds_pkg::DATA_W-1:0] s_divisor,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smds_pkg::DATA_W-1:0] m_quotient,
    output logic                               m_saturated
);
    localparam int unsigned W = smds_pkg::DATA_W;
    localparam int unsigned N = smds_pkg::DIV_CELLS;

    logic en;
    smds_pkg::div_beat_t chain [0:N];

    logic         m_valid_reg, m_valid_next;
    logic [W-1:0] quot_reg, quot_next;
    logic         sat_reg;
    logic [W-1:0] mag;

    assign en      = ~m_valid_reg | m_ready;
    assign s_ready = en;

    smds_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .a        (s_multiplicand),
        .b        (s_multiplier),
        .c        (s_divisor),
        .beat_out (chain[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        smds_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    assign mag          = chain[N].sat ? smds_pkg::SAT_MAG : chain[N].dvd;
    assign quot_next    = chain[N].neg ? (~mag + 1'b1) : mag;
    assign m_valid_next = en ? chain[N].valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= quot_next;
            sat_reg  <= chain[N].sat;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_quotient  = quot_reg;
    assign m_saturated = sat_reg;

    // a held result must not be overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_quotient) && $stable(m_saturated)))
        else $error("result changed while stalled");

    // saturated results carry the clipped magnitude
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_quotient == 32'sh7FFF_FFFF || m_quotient == 32'sh8000_0001))
        else $error("saturated result with wrong magnitude");

    // the pipe advances whenever the output slot is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for signed_mul_div_saturate
// Drives operand beats in random bursts, stalls the result side on its own
// pattern, and checks every result beat against a behavioural a*b/c model or typed-in answers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int unsigned W        = smds_pkg::DATA_W;
    localparam int unsigned N_RANDOM = 1800;
    localparam int unsigned N_DIRECT = 20;
    localparam int unsigned DRAIN    = 60;
    localparam int unsigned MAX_SHOWN = 10;

    typedef struct {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        bit                  known;  // result typed in below
        logic signed [W-1:0] q;
        logic                sat;
    } op_row_t;

    typedef struct {
        logic signed [W-1:0] q;
        logic                sat;
    } quot_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic signed [W-1:0] s_multiplicand;
    logic signed [W-1:0] s_multiplier;
    logic signed [W-1:0] s_divisor;
    logic                m_valid;
    logic                m_ready;
    logic signed [W-1:0] m_quotient;
    logic                m_saturated;

    quot_t   quot_q[$];
    op_row_t op_rows[N_DIRECT];
    int      mismatches;
    bit      stim_done;

    signed_mul_div_saturate i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_multiplicand (s_multiplicand),
        .s_multiplier   (s_multiplier),
        .s_divisor      (s_divisor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_quotient     (m_quotient),
        .m_saturated    (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic quot_t muldiv_sat(logic [W-1:0] a, logic [W-1:0] b,
                                         logic [W-1:0] c);
        quot_t       r;
        logic [W-1:0] ma, mb, mc, mag;
        logic [63:0] prod;
        logic        neg;
        ma   = a[W-1] ? -a : a;
        mb   = b[W-1] ? -b : b;
        mc   = c[W-1] ? -c : c;
        neg  = a[W-1] ^ b[W-1] ^ c[W-1];
        prod = {32'd0, ma} * {32'd0, mb};
        if (prod[63:32] >= mc) begin
            mag   = smds_pkg::SAT_MAG;
            r.sat = 1'b1;
        end else begin
            mag   = W'(prod / {32'd0, mc});
            r.sat = 1'b0;
        end
        r.q = neg ? -mag : mag;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            3: return $urandom >> $urandom_range(0, 31);
            4: return -($urandom >> $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
        s_valid        <= 1'b1;
        s_multiplicand <= a;
        s_multiplier   <= b;
        s_divisor      <= c;
        quot_q.push_back(muldiv_sat(a, b, c));
        do @(posedge aclk); while (!s_ready);
    endtask

    // burst gaps: sometimes long runs with no idling
    task automatic maybe_gap(inout int burst);
        int gap;
        if (burst > 0) begin
            burst--;
            return;
        end
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        burst = $urandom_range(1, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        int burst;
        op_rows = '{
            '{32'sd0, 32'sd0, 32'sd0, 1, 32'sh7FFF_FFFF, 1'b1},
            '{-32'sd1, 32'sd0, 32'sd0, 1, 32'sh8000_0001, 1'b1},
            '{32'sd5, 32'sd7, -32'sd0, 1, 32'sh7FFF_FFFF, 1'b1},
            '{32'sd6, 32'sd7, 32'sd2, 1, 32'sd21, 1'b0},
            '{-32'sd6, 32'sd7, 32'sd2, 1, -32'sd21, 1'b0},
            '{32'sd7, 32'sd1, -32'sd2, 1, -32'sd3, 1'b0},
            '{-32'sd7, -32'sd1, -32'sd2, 1, -32'sd3, 1'b0},
            '{32'sd0, -32'sd5, 32'sd3, 1, 32'sd0, 1'b0},
            '{32'sh8000_0000, 32'sd1, 32'sd1, 1, 32'sh8000_0000, 1'b0},
            '{32'sh8000_0000, 32'sd1, 32'sd2, 1, 32'shC000_0000, 1'b0},
            '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0},
            '{32'sh8000_0000, -32'sd1, -32'sd2, 0, 0, 0},
            '{32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0},
            '{32'sh1234_5678, 32'sh0000_0010, 32'sd3, 0, 0, 0},
            '{32'sh4000_0000, 32'sd3, 32'sd2, 0, 0, 0},
            '{32'sh4000_0000, -32'sd3, 32'sd2, 0, 0, 0},
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0},
            '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFF, 0, 0, 0}
        };
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_multiplicand = '0;
        s_multiplier   = '0;
        s_divisor      = '0;
        stim_done      = 1'b0;
        burst          = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (op_rows[i]) begin
            send_beat(op_rows[i].a, op_rows[i].b, op_rows[i].c);
            // typed-in answers take the place of the model's
            if (op_rows[i].known) begin
                quot_q[$].q   = op_rows[i].q;
                quot_q[$].sat = op_rows[i].sat;
            end
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            maybe_gap(burst);
            send_beat(rand_operand(), rand_operand(), rand_operand());
        end
        s_valid   <= 1'b0;
        stim_done <= 1'b1;
    end

    // result side stalls on a slowly changing pattern
    initial begin
        int phase;
        m_ready = 1'b0;
        phase   = 0;
        @(posedge aclk iff aresetn);
        forever begin
            phase = (phase + 1) % 400;
            if (phase < 100)
                m_ready <= 1'b1;
            else if (phase < 200)
                m_ready <= ($urandom_range(0, 3) != 0);
            else
                m_ready <= ($urandom_range(0, 1) != 0);
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        quot_t want;
        if (aresetn && m_valid && m_ready) begin
            if (quot_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected beat q=%0d sat=%b", m_quotient, m_saturated);
            end else begin
                want = quot_q.pop_front();
                if (m_quotient !== want.q || m_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("beat wrong: want q=%0d sat=%b, got q=%0d sat=%b",
                                 want.q, want.sat, m_quotient, m_saturated);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        @(posedge aclk iff stim_done);
        while (quot_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && quot_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
sv/smds_pkg.sv
sv/smds_front.sv
sv/smds_div_cell.sv
sv/signed_mul_div_saturate.sv
tb/sv/tb.sv
